>>> hdl/indexed_list_store_top_macros.svh
// ----------------------------------------------------------------------------
// indexed_list_store_top_macros.svh
// Assertion macros used by the list store core (ils_core).
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_STORE_TOP_MACROS_SVH
`define INDEXED_LIST_STORE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ILS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ILS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/ils_pkg.sv
// ----------------------------------------------------------------------------
// ils_pkg
// Types, codes and constants of the indexed list store.
// ----------------------------------------------------------------------------
`default_nettype none

package ils_pkg;

    localparam int ILS_CAPACITY = 256;
    localparam int DATA_W       = 32;
    localparam int POS_W        = 8;
    localparam int REQ_W        = 3;
    localparam int COUNT_W      = 9;
    localparam int STATUS_W     = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_BACK = 3'd0,
        REQ_POP_BACK  = 3'd1,
        REQ_SET_AT    = 3'd2,
        REQ_GET_AT    = 3'd3,
        REQ_INSERT_AT = 3'd4,
        REQ_REMOVE_AT = 3'd5
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_IGNORED = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_GET,
        S_SHIFT,
        S_INS,
        S_RD0,
        S_RDN,
        S_REPORT
    } t_state;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic signed [DATA_W-1:0] front_value;
        logic signed [DATA_W-1:0] back_value;
        logic [COUNT_W-1:0]       item_count;
        logic                     is_empty;
        t_status                  status;
    } t_result;

endpackage

`default_nettype wire

>>> hdl/ils_ram.sv
// ----------------------------------------------------------------------------
// ils_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ils_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> hdl/ils_core.sv
// ----------------------------------------------------------------------------
// ils_core
// Request sequencer, element count and shift pointer unit of the list store.
// ----------------------------------------------------------------------------
`default_nettype none

`include "indexed_list_store_top_macros.svh"

module ils_core
    import ils_pkg::*;
#(
    parameter int CAPACITY = ILS_CAPACITY
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic [REQ_W-1:0]         i_req_type,
    input  wire logic [POS_W-1:0]         i_position,
    input  wire logic signed [DATA_W-1:0] i_data_in,
    output logic                          o_busy,
    output logic                          o_done,
    output t_result                       o_result
);

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;
    localparam int XW   = (CW > COUNT_W) ? CW : COUNT_W;

    t_state                   r_state, n_state;
    logic [REQ_W-1:0]         r_req;
    logic [CMPW-1:0]          r_pos;
    logic signed [DATA_W-1:0] r_data;
    logic [CW-1:0]            r_count, n_count;
    logic [AW-1:0]            r_rptr, n_rptr;
    logic [AW-1:0]            r_last, n_last;
    logic [AW-1:0]            r_a1, n_a1;
    logic [AW-1:0]            r_a2, n_a2;
    logic                     r_rdact, n_rdact;
    logic                     r_v1, n_v1;
    logic                     r_down, n_down;
    logic signed [DATA_W-1:0] r_rd, n_rd;
    logic signed [DATA_W-1:0] r_front, n_front;
    t_status                  r_status, n_status;

    logic                     w_we;
    logic [AW-1:0]            w_waddr;
    logic [DATA_W-1:0]        w_wdata;
    logic [AW-1:0]            w_raddr;
    logic [DATA_W-1:0]        w_rdata;

    logic [CMPW-1:0]          w_count_c;
    logic [CW-1:0]            w_count_m1;
    logic [CW-1:0]            w_count_p1;
    logic [XW-1:0]            w_count_x;
    logic                     w_empty;
    logic                     w_full;
    logic                     w_pos_ge;
    logic                     w_pos_gt;
    logic                     w_pos_last;
    logic [AW-1:0]            w_pos_a;
    logic [AW-1:0]            w_pos_p1;
    logic [AW-1:0]            w_last_idx;
    logic [AW-1:0]            w_idx_sg;
    logic [AW-1:0]            w_step;
    logic                     w_at_last;

    ils_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // request decode against the current count
    always_comb begin
        w_count_c  = CMPW'(r_count);
        w_count_m1 = r_count - CW'(1);
        w_count_p1 = r_count + CW'(1);
        w_count_x  = XW'(r_count);
        w_empty    = (r_count == '0);
        w_full     = (r_count == CW'(CAPACITY));
        w_pos_ge   = (r_pos >= w_count_c);
        w_pos_gt   = (r_pos > w_count_c);
        w_pos_last = (r_pos == CMPW'(w_count_m1));
        w_pos_a    = r_pos[AW-1:0];
        w_pos_p1   = w_pos_a + AW'(1);
        w_last_idx = w_count_m1[AW-1:0];
        w_idx_sg   = w_pos_ge ? w_last_idx : w_pos_a;
    end

    // shared pointer unit: one step and one end compare per cycle
    assign w_step    = r_down ? (r_rptr - AW'(1)) : (r_rptr + AW'(1));
    assign w_at_last = (r_rptr == r_last);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (r_req)
                    REQ_GET_AT:    n_state = w_empty ? S_RD0 : S_GET;
                    REQ_INSERT_AT: n_state = (!w_full && !w_pos_ge) ? S_SHIFT : S_RD0;
                    REQ_REMOVE_AT: n_state = (!w_pos_ge && !w_pos_last) ? S_SHIFT : S_RD0;
                    default:       n_state = S_RD0;
                endcase
            end
            S_GET:   n_state = S_RD0;
            S_SHIFT: begin
                if (!r_rdact && r_v1) begin
                    n_state = (r_req == REQ_INSERT_AT) ? S_INS : S_RD0;
                end
            end
            S_INS:    n_state = S_RD0;
            S_RD0:    n_state = S_RDN;
            S_RDN:    n_state = S_REPORT;
            S_REPORT: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_count  = r_count;
        n_rptr   = r_rptr;
        n_last   = r_last;
        n_a1     = r_a1;
        n_a2     = r_a2;
        n_rdact  = r_rdact;
        n_v1     = r_v1;
        n_down   = r_down;
        n_rd     = r_rd;
        n_front  = r_front;
        n_status = r_status;
        w_we     = 1'b0;
        w_waddr  = r_a2;
        w_wdata  = w_rdata;
        w_raddr  = r_rptr;
        unique case (r_state)
            S_IDLE: begin
            end
            S_EXEC: begin
                n_rd     = '0;
                n_status = ST_DONE;
                unique case (r_req)
                    REQ_PUSH_BACK: begin
                        if (w_full) begin
                            n_status = ST_FULL;
                        end else begin
                            w_we    = 1'b1;
                            w_waddr = r_count[AW-1:0];
                            w_wdata = r_data;
                            n_count = w_count_p1;
                        end
                    end
                    REQ_POP_BACK: begin
                        if (w_empty) begin
                            n_status = ST_IGNORED;
                        end else begin
                            n_count = w_count_m1;
                        end
                    end
                    REQ_SET_AT: begin
                        if (w_empty) begin
                            n_status = ST_IGNORED;
                        end else begin
                            w_we    = 1'b1;
                            w_waddr = w_idx_sg;
                            w_wdata = r_data;
                        end
                    end
                    REQ_GET_AT: begin
                        if (w_empty) begin
                            n_status = ST_IGNORED;
                        end else begin
                            w_raddr = w_idx_sg;
                        end
                    end
                    REQ_INSERT_AT: begin
                        if (w_full) begin
                            n_status = ST_FULL;
                        end else if (w_pos_gt) begin
                            n_status = ST_IGNORED;
                        end else if (w_pos_ge) begin
                            // insert at the end: no shift
                            w_we    = 1'b1;
                            w_waddr = w_pos_a;
                            w_wdata = r_data;
                            n_count = w_count_p1;
                        end else begin
                            // move words down from the back: last word lands at count
                            n_rptr  = w_last_idx;
                            n_last  = w_pos_a;
                            n_a1    = r_count[AW-1:0];
                            n_down  = 1'b1;
                            n_rdact = 1'b1;
                            n_v1    = 1'b0;
                        end
                    end
                    REQ_REMOVE_AT: begin
                        if (w_pos_ge) begin
                            n_status = ST_IGNORED;
                        end else if (w_pos_last) begin
                            n_count = w_count_m1;
                        end else begin
                            n_rptr  = w_pos_p1;
                            n_last  = w_last_idx;
                            n_a1    = w_pos_a;
                            n_down  = 1'b0;
                            n_rdact = 1'b1;
                            n_v1    = 1'b0;
                        end
                    end
                    default: n_status = ST_IGNORED;
                endcase
            end
            S_GET: begin
                n_rd = w_rdata;
            end
            S_SHIFT: begin
                // read word k, write it in the next cycle to the address read before it
                w_we   = r_v1;
                n_a1   = r_rptr;
                n_a2   = r_a1;
                n_v1   = r_rdact;
                if (r_rdact) begin
                    if (w_at_last) begin
                        n_rdact = 1'b0;
                    end else begin
                        n_rptr = w_step;
                    end
                end
                if (!r_rdact && r_v1 && r_req == REQ_REMOVE_AT) begin
                    n_count = w_count_m1;
                end
            end
            S_INS: begin
                w_we    = 1'b1;
                w_waddr = w_pos_a;
                w_wdata = r_data;
                n_count = w_count_p1;
            end
            S_RD0: begin
                w_raddr = '0;
            end
            S_RDN: begin
                w_raddr = w_last_idx;
                n_front = w_rdata;
            end
            S_REPORT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_rdact  <= 1'b0;
            r_v1     <= 1'b0;
            r_status <= ST_DONE;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_rdact  <= n_rdact;
            r_v1     <= n_v1;
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_req  <= i_req_type;
            r_pos  <= CMPW'(i_position);
            r_data <= i_data_in;
        end
        r_rptr  <= n_rptr;
        r_last  <= n_last;
        r_a1    <= n_a1;
        r_a2    <= n_a2;
        r_down  <= n_down;
        r_rd    <= n_rd;
        r_front <= n_front;
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_REPORT);

    always_comb begin
        o_result.read_value  = r_rd;
        o_result.front_value = w_empty ? '0 : r_front;
        o_result.back_value  = w_empty ? '0 : $signed(w_rdata);
        o_result.item_count  = w_count_x[COUNT_W-1:0];
        o_result.is_empty    = w_empty;
        o_result.status      = r_status;
    end

    `ILS_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(CAPACITY), "count above capacity")
    `ILS_ASSERT_NEXT(a_accept_exec, i_clk, i_rst_n, r_state == S_IDLE && i_start, r_state == S_EXEC, "accepted word not executed")
    `ILS_ASSERT_SAME(a_shift_ports, i_clk, i_rst_n, r_state == S_SHIFT && r_v1 && r_rdact, r_a2 != r_rptr, "shift write hits read address")
    `ILS_ASSERT_SAME(a_full_status, i_clk, i_rst_n, o_done && r_status == ST_FULL, w_full, "full status with room left")
    `ILS_ASSERT_NEXT(a_idle_count, i_clk, i_rst_n, r_state == S_IDLE, r_count == $past(r_count), "count moved while idle")

endmodule

`default_nettype wire

>>> hdl/indexed_list_store_top.sv
// ----------------------------------------------------------------------------
// indexed_list_store_top
// Bounded ordered list of signed 32-bit words with indexed access.
// ----------------------------------------------------------------------------
// Input channel: a request word (i_req_type, i_position, i_data_in) is taken
// at a rising edge where start is high and busy is low. busy stays high from
// the cycle after that edge until the result cycle.
// Output channel: o_valid is high for one cycle with the result word on the
// o_ ports; it is taken at the edge ending that cycle. There is no stall.
// Sequence from the accepting edge to the o_valid cycle: every request runs
// through the execute state, the front and back reads, the report state and
// the result register. A get on a non-empty list adds a read state; an insert
// at k < count into a list that is not full, or a remove at k < count - 1,
// adds the shift state, and such an insert then a write state for the new word.
// The shift is one word per cycle through the element RAM (one read and one
// write port, registered read); front and back are read back from that RAM
// after every request. A new request may be given in the o_valid cycle.
// Reset clears the count to empty and returns the sequencer to idle; the RAM
// contents are not cleared, and no word reaches the outputs before it is written.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_list_store_top
    import ils_pkg::*;
#(
    parameter int CAPACITY = ILS_CAPACITY
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [REQ_W-1:0]         i_req_type,
    input  wire logic [POS_W-1:0]         i_position,
    input  wire logic signed [DATA_W-1:0] i_data_in,
    output logic                          o_valid,
    output logic signed [DATA_W-1:0]      o_read_value,
    output logic signed [DATA_W-1:0]      o_front_value,
    output logic signed [DATA_W-1:0]      o_back_value,
    output logic [COUNT_W-1:0]            o_item_count,
    output logic                          o_is_empty,
    output logic [STATUS_W-1:0]           o_status
);

    logic    w_busy;
    logic    w_done;
    t_result w_result;
    logic    r_valid;
    t_result r_result;

    ils_core #(
        .CAPACITY (CAPACITY)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_req_type),
        .i_position (i_position),
        .i_data_in  (i_data_in),
        .o_busy     (w_busy),
        .o_done     (w_done),
        .o_result   (w_result)
    );

    // result register: one-cycle strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_result <= w_result;
        end
    end

    assign busy          = w_busy;
    assign o_valid       = r_valid;
    assign o_read_value  = r_result.read_value;
    assign o_front_value = r_result.front_value;
    assign o_back_value  = r_result.back_value;
    assign o_item_count  = r_result.item_count;
    assign o_is_empty    = r_result.is_empty;
    assign o_status      = r_result.status;

endmodule

`default_nettype wire
